/* rtl/qmn_pkg.sv */
// Shared constants and helpers of the normalized quaternion product.
`default_nettype none
package qmn_pkg;
    localparam int unsigned QMN_COMP_W      = 16;
    localparam int unsigned QMN_QUEUE_DEPTH = 4;

    function automatic int unsigned qmn_entry_w(input int unsigned comp_w);
        return 1 + (4 * comp_w + 4) + 4 * (4 * comp_w + 2) + 4 + 4 * comp_w;
    endfunction
endpackage
`default_nettype wire

/* rtl/quaternion_multiply_normalize.sv */
// Top level of the normalized quaternion product.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_first_x..w, i_second_x..w
//   result  | out       | o_valid / i_stall  | o_unit_x..w, o_length_floored
//
// One item is taken per cycle while o_stall is low. The path runs through the five
// front stages, the queue and one back stage per bit of the rounded quotient. Reset
// is synchronous and clears the valid flags and the queue pointers.
// A stalled result holds the back end; the queue then fills before the input stalls.
`default_nettype none
module quaternion_multiply_normalize import qmn_pkg::*; #(
    parameter int unsigned COMPONENT_WIDTH = QMN_COMP_W,
    parameter int unsigned QUEUE_DEPTH     = QMN_QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_first_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_first_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_first_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_first_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_second_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_second_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_second_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_second_w,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [COMPONENT_WIDTH-1:0]      o_unit_x,
    output logic signed [COMPONENT_WIDTH-1:0]      o_unit_y,
    output logic signed [COMPONENT_WIDTH-1:0]      o_unit_z,
    output logic signed [COMPONENT_WIDTH-1:0]      o_unit_w,
    output logic                                   o_length_floored
);
    localparam int unsigned ENTRY_W = qmn_entry_w(COMPONENT_WIDTH);

    logic signed [COMPONENT_WIDTH-1:0] w_a [0:3];
    logic signed [COMPONENT_WIDTH-1:0] w_b [0:3];
    logic [COMPONENT_WIDTH-1:0]        w_unit [0:3];
    logic                              w_push, w_full, w_pop, w_q_valid;
    logic [ENTRY_W-1:0]                w_in_entry, w_out_entry;

    assign w_a = '{i_first_x, i_first_y, i_first_z, i_first_w};
    assign w_b = '{i_second_x, i_second_y, i_second_z, i_second_w};

    qmn_front #(.COMP_W(COMPONENT_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_in_entry)
    );

    qmn_queue #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_out_entry)
    );

    qmn_back #(.COMP_W(COMPONENT_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_entry   (w_out_entry),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_unit    (w_unit),
        .o_floored (o_length_floored)
    );

    assign o_unit_x = w_unit[0];
    assign o_unit_y = w_unit[1];
    assign o_unit_z = w_unit[2];
    assign o_unit_w = w_unit[3];
endmodule
`default_nettype wire

/* rtl/qmn_front.sv */
// Front end: Hamilton product, component magnitudes, squared length and floor test.
`default_nettype none
module qmn_front import qmn_pkg::*; #(
    parameter int unsigned COMP_W = QMN_COMP_W,
    localparam int unsigned ENTRY_W = qmn_entry_w(COMP_W)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [COMP_W-1:0] i_a [0:3],
    input  wire logic signed [COMP_W-1:0] i_b [0:3],
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output logic [ENTRY_W-1:0]            o_entry
);
    localparam int unsigned FRAC_W = COMP_W - 2;
    localparam int unsigned PR_W   = 2 * COMP_W;
    localparam int unsigned P_W    = 2 * COMP_W + 2;
    localparam int unsigned M_W    = 2 * COMP_W + 1;
    localparam int unsigned HI_W   = COMP_W + 1;
    localparam int unsigned SQ_W   = 4 * COMP_W + 2;
    localparam int unsigned SUM_W  = 4 * COMP_W + 4;
    localparam int unsigned NEG_LO = 4 * COMP_W;
    localparam int unsigned SQ_LO  = NEG_LO + 4;
    localparam int unsigned SUM_LO = SQ_LO + 4 * SQ_W;
    localparam int unsigned FL_BIT = SUM_LO + SUM_W;

    localparam logic [1:0] PARTNER [0:3][0:3] = '{
        '{2'd3, 2'd2, 2'd1, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd3}
    };
    localparam logic SUBTRACT [0:3][0:3] = '{
        '{1'b0, 1'b0, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1, 1'b0}
    };

    logic                     w_en;
    logic [4:0]               r_v;
    logic signed [PR_W-1:0]   n_prod [0:3][0:3];
    logic signed [PR_W-1:0]   r_prod [0:3][0:3];
    logic [M_W-1:0]           n_mag [0:3];
    logic [3:0]               n_neg;
    logic [COMP_W-1:0]        n_pl [0:3];
    logic [M_W-1:0]           r_mag [0:3];
    logic [3:0]               r_neg2, r_neg3, r_neg4, r_neg5;
    logic [COMP_W-1:0]        r_pl2 [0:3];
    logic [COMP_W-1:0]        r_pl3 [0:3];
    logic [COMP_W-1:0]        r_pl4 [0:3];
    logic [COMP_W-1:0]        r_pl5 [0:3];
    logic [2*HI_W-1:0]        r_hh [0:3];
    logic [HI_W+COMP_W-1:0]   r_hl [0:3];
    logic [2*COMP_W-1:0]      r_ll [0:3];
    logic [SQ_W-1:0]          n_sq [0:3];
    logic [SQ_W-1:0]          r_sq4 [0:3];
    logic [SQ_W-1:0]          r_sq5 [0:3];
    logic [SUM_W-1:0]         n_sum;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_fl;

    assign w_en    = !(r_v[4] && i_q_full);
    assign o_stall = !w_en;
    assign o_push  = w_en && r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int t = 0; t < 4; t++) begin
                n_prod[c][t] = i_a[t] * i_b[PARTNER[c][t]];
            end
        end
    end

    always_comb begin : p_sum
        logic signed [P_W-1:0] acc;
        logic signed [P_W-1:0] term;
        for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int t = 0; t < 4; t++) begin
                term = P_W'(r_prod[c][t]);
                acc  = SUBTRACT[c][t] ? acc - term : acc + term;
            end
            n_neg[c] = acc[P_W-1];
            n_mag[c] = acc[P_W-1] ? M_W'(-acc) : M_W'(acc);
            n_pl[c]  = acc[COMP_W-1:0];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sq[c] = (SQ_W'(r_hh[c]) << (2 * COMP_W)) + (SQ_W'(r_hl[c]) << (COMP_W + 1))
                    + SQ_W'(r_ll[c]);
        end
        n_sum = SUM_W'(r_sq4[0]) + SUM_W'(r_sq4[1]) + SUM_W'(r_sq4[2]) + SUM_W'(r_sq4[3]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= n_prod;
            r_mag  <= n_mag;
            r_neg2 <= n_neg;
            r_pl2  <= n_pl;
            for (int c = 0; c < 4; c++) begin
                r_hh[c] <= r_mag[c][M_W-1:COMP_W] * r_mag[c][M_W-1:COMP_W];
                r_hl[c] <= r_mag[c][M_W-1:COMP_W] * r_mag[c][COMP_W-1:0];
                r_ll[c] <= r_mag[c][COMP_W-1:0] * r_mag[c][COMP_W-1:0];
            end
            r_neg3 <= r_neg2;
            r_pl3  <= r_pl2;
            r_sq4  <= n_sq;
            r_neg4 <= r_neg3;
            r_pl4  <= r_pl3;
            r_sq5  <= r_sq4;
            r_sum  <= n_sum;
            r_fl   <= n_sum < (SUM_W'(1) << (2 * FRAC_W));
            r_neg5 <= r_neg4;
            r_pl5  <= r_pl4;
        end
    end

    always_comb begin
        o_entry = '0;
        for (int c = 0; c < 4; c++) begin
            o_entry[c*COMP_W +: COMP_W]   = r_pl5[c];
            o_entry[SQ_LO + c*SQ_W +: SQ_W] = r_sq5[c];
        end
        o_entry[NEG_LO +: 4]     = r_neg5;
        o_entry[SUM_LO +: SUM_W] = r_sum;
        o_entry[FL_BIT]          = r_fl;
    end
endmodule
`default_nettype wire

/* rtl/qmn_queue.sv */
// Short queue that decouples the front end from the normalizing back end.
`default_nettype none
module qmn_queue import qmn_pkg::*; #(
    parameter int unsigned DATA_W = qmn_entry_w(QMN_COMP_W),
    parameter int unsigned DEPTH  = QMN_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

/* rtl/qmn_back.sv */
// Back end: bit-by-bit rounded division of each component by the length; a floored item passes its product's low bits.
`default_nettype none
module qmn_back import qmn_pkg::*; #(
    parameter int unsigned COMP_W = QMN_COMP_W,
    localparam int unsigned ENTRY_W = qmn_entry_w(COMP_W)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [COMP_W-1:0]       o_unit [0:3],
    output logic                    o_floored
);
    localparam int unsigned FRAC_W = COMP_W - 2;
    localparam int unsigned NST    = FRAC_W + 1;
    localparam int unsigned SQ_W   = 4 * COMP_W + 2;
    localparam int unsigned SUM_W  = 4 * COMP_W + 4;
    localparam int unsigned RW     = 6 * COMP_W + 4;
    localparam int unsigned NEG_LO = 4 * COMP_W;
    localparam int unsigned SQ_LO  = NEG_LO + 4;
    localparam int unsigned SUM_LO = SQ_LO + 4 * SQ_W;
    localparam int unsigned FL_BIT = SUM_LO + SUM_W;

    logic                   w_en;
    logic [NST:0]           r_v;
    logic                   r_ov;
    logic signed [RW-1:0]   r_rem [0:NST-1][0:3];
    logic signed [RW-1:0]   r_y   [0:NST-1][0:3];
    logic [SUM_W-1:0]       r_s   [0:NST-1];
    logic [FRAC_W:0]        r_m   [0:NST][0:3];
    logic                   r_fl  [0:NST];
    logic [3:0]             r_neg [0:NST];
    logic [COMP_W-1:0]      r_pl  [0:NST][0:3];
    logic [SUM_W-1:0]       w_sum;

    assign w_en    = !r_ov || !i_stall;
    assign o_pop   = w_en && i_q_valid;
    assign o_valid = r_ov;
    assign w_sum   = i_entry[SUM_LO +: SUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v  <= {r_v[NST-1:0], i_q_valid};
            r_ov <= r_v[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r_rem[0][c] <= (RW'(i_entry[SQ_LO + c*SQ_W +: SQ_W]) << (2 * FRAC_W + 2))
                             - RW'(w_sum);
                r_y[0][c]   <= -RW'(w_sum);
                r_m[0][c]   <= '0;
                r_pl[0][c]  <= i_entry[c*COMP_W +: COMP_W];
            end
            r_s[0]   <= w_sum;
            r_fl[0]  <= i_entry[FL_BIT];
            r_neg[0] <= i_entry[NEG_LO +: 4];
        end
    end

    for (genvar s = 1; s <= NST; s++) begin : g_stage
        localparam int unsigned BIT = FRAC_W - (s - 1);
        logic signed [RW-1:0] n_t [0:3];
        logic [3:0]           n_take;

        always_comb begin
            for (int c = 0; c < 4; c++) begin
                n_t[c] = r_rem[s-1][c] - (r_y[s-1][c] <<< (BIT + 2))
                       - (RW'(r_s[s-1]) << (2 * BIT + 2));
                n_take[c] = !n_t[c][RW-1] && ((BIT == FRAC_W) || !r_m[s-1][c][FRAC_W]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int c = 0; c < 4; c++) begin
                    r_m[s][c] <= r_m[s-1][c] | (n_take[c] ? ((FRAC_W+1)'(1) << BIT) : '0);
                end
                r_pl[s]  <= r_pl[s-1];
                r_fl[s]  <= r_fl[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end

        if (s < NST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    for (int c = 0; c < 4; c++) begin
                        r_rem[s][c] <= n_take[c] ? n_t[c] : r_rem[s-1][c];
                        r_y[s][c]   <= n_take[c] ? r_y[s-1][c] + (RW'(r_s[s-1]) << (BIT + 1))
                                                 : r_y[s-1][c];
                    end
                    r_s[s] <= r_s[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                if (r_fl[NST]) begin
                    o_unit[c] <= r_pl[NST][c];
                end else if (r_neg[NST][c]) begin
                    o_unit[c] <= -COMP_W'(r_m[NST][c]);
                end else begin
                    o_unit[c] <= COMP_W'(r_m[NST][c]);
                end
            end
            o_floored <= r_fl[NST];
        end
    end
endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the normalized quaternion product.
module testbench;
    import qmn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = QMN_COMP_W;
    localparam int FRAC = W - 2;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 4 * W;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 930;

    typedef logic signed [W-1:0] comp_t;
    typedef struct {
        comp_t a[4];
        comp_t b[4];
    } quat_pair_t;
    typedef struct {
        comp_t unit[4];
        logic  floored;
    } unit_quat_t;

    class unit_scoreboard;
        unit_quat_t expected_units[$];
        int mismatches;
        int transfers_in;
        int transfers_out;
        int floored_seen;

        function unit_quat_t normalize_product(quat_pair_t q);
            unit_quat_t r;
            longint ax, ay, az, aw, bx, by, bz, bw;
            longint p[4];
            logic [127:0] mag[4];
            logic [127:0] len_sq;
            logic [127:0] rhs;
            logic [127:0] odd;
            longint lo, hi, mid;
            ax = q.a[0]; ay = q.a[1]; az = q.a[2]; aw = q.a[3];
            bx = q.b[0]; by = q.b[1]; bz = q.b[2]; bw = q.b[3];
            p[0] = ax * bw + ay * bz - az * by + aw * bx;
            p[1] = -ax * bz + ay * bw + az * bx + aw * by;
            p[2] = ax * by - ay * bx + az * bw + aw * bz;
            p[3] = -ax * bx - ay * by - az * bz + aw * bw;
            len_sq = '0;
            for (int c = 0; c < 4; c++) begin
                mag[c] = (p[c] < 0) ? 128'(-p[c]) : 128'(p[c]);
                len_sq += mag[c] * mag[c];
            end
            r.floored = (len_sq < (128'd1 << (2 * FRAC)));
            for (int c = 0; c < 4; c++) begin
                if (r.floored) begin
                    r.unit[c] = comp_t'(p[c]);
                end else begin
                    rhs = (mag[c] * mag[c]) << (2 * FRAC + 2);
                    lo = 0;
                    hi = longint'(1) << FRAC;
                    while (lo < hi) begin
                        mid = (lo + hi + 1) >>> 1;
                        odd = 128'(2 * mid - 1);
                        if (odd * odd * len_sq <= rhs) begin
                            lo = mid;
                        end else begin
                            hi = mid - 1;
                        end
                    end
                    r.unit[c] = (p[c] < 0) ? comp_t'(-lo) : comp_t'(lo);
                end
            end
            return r;
        endfunction

        function void note_input(quat_pair_t q);
            expected_units.push_back(normalize_product(q));
            transfers_in++;
        endfunction

        function void check_result(unit_quat_t got);
            unit_quat_t exp_r;
            transfers_out++;
            if (got.floored) floored_seen++;
            if (expected_units.size() == 0) begin
                $display("%0t: result with nothing expected: %0d %0d %0d %0d floored %0b",
                         $time, got.unit[0], got.unit[1], got.unit[2], got.unit[3],
                         got.floored);
                mismatches++;
                return;
            end
            exp_r = expected_units.pop_front();
            for (int c = 0; c < 4; c++) begin
                if (got.unit[c] !== exp_r.unit[c]) begin
                    $display("%0t: unit component %0d expected %0d actual %0d",
                             $time, c, exp_r.unit[c], got.unit[c]);
                    mismatches++;
                end
            end
            if (got.floored !== exp_r.floored) begin
                $display("%0t: length_floored expected %0b actual %0b",
                         $time, exp_r.floored, got.floored);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_units.size();
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    comp_t i_first_x = '0, i_first_y = '0, i_first_z = '0, i_first_w = '0;
    comp_t i_second_x = '0, i_second_y = '0, i_second_z = '0, i_second_w = '0;
    logic  o_stall, o_valid, o_length_floored;
    comp_t o_unit_x, o_unit_y, o_unit_z, o_unit_w;

    unit_scoreboard sb = new();
    bit hold_request = 1'b0;
    int idle_cycles = 0;
    int burst_left = 0;

    quaternion_multiply_normalize dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_first_x(i_first_x), .i_first_y(i_first_y),
        .i_first_z(i_first_z), .i_first_w(i_first_w),
        .i_second_x(i_second_x), .i_second_y(i_second_y),
        .i_second_z(i_second_z), .i_second_w(i_second_w),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_unit_x(o_unit_x), .o_unit_y(o_unit_y),
        .o_unit_z(o_unit_z), .o_unit_w(o_unit_w),
        .o_length_floored(o_length_floored)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        unit_quat_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.unit[0] = o_unit_x;
            got.unit[1] = o_unit_y;
            got.unit[2] = o_unit_z;
            got.unit[3] = o_unit_w;
            got.floored = o_length_floored;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // The receiver alternates between free running, random stalls and a regular
    // stall pattern; on request it holds off for a long stretch.
    initial begin
        int phase_len;
        int mode;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                phase_len = $urandom_range(40, 1);
                mode = $urandom_range(2, 0);
                for (int n = 0; n < phase_len; n++) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(99, 0) < 35);
                        default: i_stall <= (n % 3 == 2);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_pair(input quat_pair_t q);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        i_first_x <= q.a[0]; i_first_y <= q.a[1]; i_first_z <= q.a[2]; i_first_w <= q.a[3];
        i_second_x <= q.b[0]; i_second_y <= q.b[1]; i_second_z <= q.b[2];
        i_second_w <= q.b[3];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(q);
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic quat_pair_t uniform_pair(comp_t v);
        quat_pair_t q;
        for (int c = 0; c < 4; c++) begin
            q.a[c] = v;
            q.b[c] = v;
        end
        return q;
    endfunction

    function automatic quat_pair_t random_pair(int kind);
        quat_pair_t q;
        int span;
        span = (kind == 0) ? 0 : (kind == 1) ? 200 : (kind == 2) ? 3 : 16384;
        for (int c = 0; c < 4; c++) begin
            if (span == 0) begin
                q.a[c] = comp_t'($urandom());
                q.b[c] = comp_t'($urandom());
            end else begin
                q.a[c] = comp_t'($urandom_range(2 * span, 0) - span);
                q.b[c] = comp_t'($urandom_range(2 * span, 0) - span);
            end
        end
        return q;
    endfunction

    initial begin
        quat_pair_t directed[$];
        quat_pair_t q;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(uniform_pair('0));
        directed.push_back(uniform_pair(comp_t'(-32768)));
        directed.push_back(uniform_pair(comp_t'(32767)));
        directed.push_back(uniform_pair(comp_t'(1)));
        directed.push_back(uniform_pair(comp_t'(-1)));
        directed.push_back(uniform_pair(comp_t'(16384)));
        q = uniform_pair('0); q.a[3] = 16384; q.b[3] = 16384;
        directed.push_back(q);
        q = uniform_pair('0); q.a[3] = 1; q.b[3] = 1;
        directed.push_back(q);
        q = uniform_pair('0); q.a[3] = 1; q.b[3] = 16384;
        directed.push_back(q);
        q = uniform_pair('0); q.a[3] = 1; q.b[3] = 16383;
        directed.push_back(q);
        q = uniform_pair('0); q.a[0] = -128; q.b[0] = 127;
        directed.push_back(q);
        q = uniform_pair('0); q.a[0] = -32768; q.b[3] = 32767; q.a[1] = 5; q.b[2] = -3;
        directed.push_back(q);
        q = uniform_pair('0); q.a[1] = 32767; q.b[1] = -32768;
        directed.push_back(q);
        q = uniform_pair('0); q.a[2] = 3; q.b[3] = 3; q.a[3] = 4; q.b[2] = 4;
        directed.push_back(q);
        q = uniform_pair('0); q.a[0] = 1; q.a[3] = 1; q.b[3] = 16384;
        directed.push_back(q);
        foreach (directed[k]) send_pair(directed[k]);

        wait_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) begin
                wait_until_drained();
            end
            if (n == 500) begin
                hold_request = 1'b1;
                for (int k = 0; k < 40; k++) begin
                    burst_left = 40;
                    send_pair(random_pair(0));
                end
            end
            send_pair(random_pair($urandom_range(3, 0)));
        end
        wait_until_drained();

        $display("Sent %0d quaternion pairs and checked %0d normalized products, %0d floored.",
                 sb.transfers_in, sb.transfers_out, sb.floored_seen);
        $display("Senders and receivers idled at random, with one long receiver hold-off.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
